// ===== design/wpbt_pkg.sv =====
// Shared types and constants for the W' balance tracker.
// Used by wpbt_ctrl, wpbt_datapath and w_prime_balance_tracker; no dependencies.
`default_nettype none

package wpbt_pkg;

  // field widths
  localparam int unsigned TIME_W     = 24;
  localparam int unsigned POWER_W    = 12;
  localparam int unsigned CP_W       = 12;
  localparam int unsigned RC_W       = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned BAL_W      = 32;
  localparam int unsigned TOTAL_W    = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_POWER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_GAP_LIMIT   = 2'd2;

  localparam logic [CP_W-1:0]    CP_RESET    = 12'd250;
  localparam logic [RC_W-1:0]    RC_RESET    = 16'd20000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd30;

  // datapath widths
  localparam int unsigned DT_W      = 16;                  // gap after range check
  localparam int unsigned PDIFF_W   = 12;                  // |P - CP|
  localparam int unsigned PROD_A_W  = PDIFF_W + DT_W;      // |P - CP| * dt
  localparam int unsigned MAG_W     = 33;                  // |W' - bal|
  localparam int unsigned MAG_LO_W  = 16;
  localparam int unsigned NUM_W     = PROD_A_W + MAG_W;    // dividend
  localparam int unsigned DIV_STEPS = (NUM_W + 1) / 2;     // two quotient bits a cycle
  localparam int unsigned DIV_W     = 2 * DIV_STEPS;
  localparam int unsigned REM_W     = RC_W + 1;
  localparam int unsigned WIDE_W    = NUM_W + 2;           // balance before saturation
  localparam int unsigned CMP_W     = BAL_W + 4;           // threshold compares

  typedef struct packed {
    logic [CP_W-1:0]    critical_power;
    logic [RC_W-1:0]    reserve_capacity;
    logic [LIMIT_W-1:0] stop_gap_limit;
  } cfg_t;

  typedef struct packed {
    logic load;      // capture input beat
    logic check;     // qualify point, update previous point, handle restart
    logic mul1;      // |P-CP|*dt and |W'-bal|
    logic mul_lo;    // low partial product
    logic mul_hi;    // high partial product
    logic div_step;  // two restoring divide steps
    logic bal;       // apply drain or recovery, saturate
    logic stat;      // update minimum and match count, load output
  } dp_cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic drain;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/w_prime_balance_tracker.sv =====
// W' balance tracker top level: configuration registers, sequencer and datapath.
// Instantiates wpbt_ctrl and wpbt_datapath; uses wpbt_pkg.
//
// Usage: power points arrive on the input channel (in_valid_i / in_stall_o) as
// start_ride_i, time_offset_i and power_watts_i. Each qualifying point yields one
// beat on the output channel (out_valid_o / out_stall_i) carrying the new W'
// balance, the running minimum and the match count; restart, disabled and
// skipped points yield nothing. One point is worked on at a time; the next is
// taken once the sequencer is back in idle. A point that yields no sample
// stops after the check; a point above CP goes on to the balance update; a
// recovery point also runs the split multiply and the radix-4 restoring
// divider by W' on the 61-bit dividend.
// A finished sample sits in the output register; while the receiver stalls the
// sequencer holds in its last state, so at most one point waits behind it.
// Reset restores CP 250 W, W' 20000 J, gap limit 30 s, a full balance and
// cleared history. Configuration writes (cfg_we_i) are registered and
// belong only in idle periods.
`default_nettype none

module w_prime_balance_tracker import wpbt_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      start_ride_i,
  input  logic signed [TIME_W-1:0]  time_offset_i,
  input  logic [POWER_W-1:0]        power_watts_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [TIME_W-1:0]  sample_time_o,
  output logic signed [BAL_W-1:0]   balance_q8_o,
  output logic [POWER_W-1:0]        sample_power_o,
  output logic [TOTAL_W-1:0]        match_total_o,
  output logic signed [BAL_W-1:0]   lowest_balance_q8_o
);

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.critical_power   <= CP_RESET;
      cfg_q.reserve_capacity <= RC_RESET;
      cfg_q.stop_gap_limit   <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CRITICAL_POWER:   cfg_q.critical_power   <= cfg_data_i[CP_W-1:0];
        CFG_RESERVE_CAPACITY: cfg_q.reserve_capacity <= cfg_data_i[RC_W-1:0];
        CFG_STOP_GAP_LIMIT:   cfg_q.stop_gap_limit   <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  wpbt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .idle_o       (idle)
  );

  wpbt_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .cmd_i               (cmd),
    .status_o            (status),
    .start_ride_i        (start_ride_i),
    .time_offset_i       (time_offset_i),
    .power_watts_i       (power_watts_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .sample_time_o       (sample_time_o),
    .balance_q8_o        (balance_q8_o),
    .sample_power_o      (sample_power_o),
    .match_total_o       (match_total_o),
    .lowest_balance_q8_o (lowest_balance_q8_o)
  );

  assign in_stall_o = !idle;

endmodule

`default_nettype wire

// ===== design/wpbt_ctrl.sv =====
// Sequencer for the W' balance tracker: one-hot state machine issuing datapath commands.
// Depends on wpbt_pkg for the command and status structs.
`default_nettype none

module wpbt_ctrl import wpbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       idle_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHECK  = 8'b0000_0010,
    ST_MUL1   = 8'b0000_0100,
    ST_MUL_LO = 8'b0000_1000,
    ST_MUL_HI = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_BAL    = 8'b0100_0000,
    ST_STAT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = item_valid_i;
        if (item_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = status_i.sample_ok ? ST_MUL1 : ST_IDLE;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = status_i.drain ? ST_BAL : ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = ST_BAL;
      end
      ST_BAL: begin
        cmd_o.bal = 1'b1;
        state_d = ST_STAT;
      end
      ST_STAT: begin
        // hold until the output register can take the beat
        cmd_o.stat = 1'b1;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && item_valid_i |=> (state_q == ST_CHECK))
    else $error("accepted beat did not start a check");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && !status_i.div_done |=> (state_q == ST_DIV))
    else $error("divider left before its last step");

endmodule

`default_nettype wire

// ===== design/wpbt_datapath.sv =====
// Datapath for the W' balance tracker: ride state, split multiplier, radix-4 divider,
// balance saturation, minimum and match statistics, output register. Uses wpbt_pkg.
`default_nettype none

module wpbt_datapath import wpbt_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                status_o,
  input  logic                      start_ride_i,
  input  logic signed [TIME_W-1:0]  time_offset_i,
  input  logic [POWER_W-1:0]        power_watts_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic signed [TIME_W-1:0]  sample_time_o,
  output logic signed [BAL_W-1:0]   balance_q8_o,
  output logic [POWER_W-1:0]        sample_power_o,
  output logic [TOTAL_W-1:0]        match_total_o,
  output logic signed [BAL_W-1:0]   lowest_balance_q8_o
);

  localparam int unsigned WQ_W = RC_W + FRACTION_BITS;
  localparam int unsigned CNT_EXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic signed [CMP_W-1:0] CMP_BAL_MAX = (CMP_W'(1) << (BAL_W - 1)) - CMP_W'(1);
  localparam logic signed [WIDE_W-1:0] WIDE_BAL_MAX =
    (WIDE_W'(1) << (BAL_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] WIDE_BAL_MIN = -(WIDE_W'(1) << (BAL_W - 1));
  localparam logic [CMP_W-1:0] RESET_WQ = CMP_W'(RC_RESET) << FRACTION_BITS;
  localparam logic [BAL_W-1:0] RESET_BAL =
    ($signed(RESET_WQ) > CMP_BAL_MAX) ? CMP_BAL_MAX[BAL_W-1:0] : RESET_WQ[BAL_W-1:0];

  // captured beat
  logic                     item_start_q;
  logic signed [TIME_W-1:0] item_time_q;
  logic [POWER_W-1:0]       item_power_q;

  // ride state
  logic signed [TIME_W-1:0] prior_time_q;
  logic                     prior_seen_q;
  logic signed [BAL_W-1:0]  bal_q, bal_d;
  logic signed [BAL_W-1:0]  lowest_q, lowest_d;
  logic                     seen_q, seen_d;
  logic                     armed_q, armed_d;
  logic [COUNT_BITS-1:0]    count_q, count_d;

  // working registers
  logic [DT_W-1:0]      dt_q;
  logic [PDIFF_W-1:0]   pdiff_q;
  logic                 drain_q;
  logic [PROD_A_W-1:0]  prod_a_q;
  logic [MAG_W-1:0]     mag_q;
  logic                 mag_neg_q;
  logic [DIV_W-1:0]     acc_q, acc_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  // output register
  logic                     out_valid_q;
  logic signed [TIME_W-1:0] out_time_q;
  logic signed [BAL_W-1:0]  out_bal_q;
  logic [POWER_W-1:0]       out_power_q;
  logic [TOTAL_W-1:0]       out_total_q;
  logic signed [BAL_W-1:0]  out_low_q;

  logic [WQ_W-1:0]          wq;
  logic signed [CMP_W-1:0]  wq_c;
  logic signed [CMP_W-1:0]  wq3_c;
  logic [BAL_W-1:0]         full_sat;
  logic signed [TIME_W:0]   dt_full;
  logic                     gap_ok;
  logic                     drain_now;
  logic                     out_free;
  logic                     commit;
  logic signed [CMP_W-1:0]  diff_c;
  logic signed [CMP_W-1:0]  bal_c;
  logic signed [CMP_W-1:0]  twice_c;
  logic signed [CMP_W-1:0]  quad_c;
  logic signed [WIDE_W-1:0] wide;
  logic signed [WIDE_W-1:0] wq_wide;
  logic signed [WIDE_W-1:0] bal_wide;
  logic [CNT_EXT_W-1:0]     count_ext;

  assign wq      = WQ_W'(cfg_i.reserve_capacity) << FRACTION_BITS;
  assign wq_c    = $signed(CMP_W'(wq));
  assign wq3_c   = wq_c + (wq_c <<< 1);
  assign full_sat = (wq_c > CMP_BAL_MAX) ? CMP_BAL_MAX[BAL_W-1:0] : wq_c[BAL_W-1:0];

  // point qualification
  assign dt_full = {item_time_q[TIME_W-1], item_time_q}
                 - {prior_time_q[TIME_W-1], prior_time_q};
  assign gap_ok  = prior_seen_q && !item_time_q[TIME_W-1] && !prior_time_q[TIME_W-1]
                && !dt_full[TIME_W] && (dt_full != '0)
                && (dt_full[TIME_W-1:0] <= TIME_W'(cfg_i.stop_gap_limit));
  assign drain_now = item_power_q > cfg_i.critical_power;

  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = cmd_i.stat && out_free;

  assign status_o.sample_ok = !item_start_q && (cfg_i.critical_power != '0)
                           && (cfg_i.reserve_capacity != '0) && gap_ok;
  assign status_o.drain     = drain_q;
  assign status_o.div_done  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.out_free  = out_free;

  assign bal_c  = CMP_W'(bal_q);
  assign diff_c = wq_c - bal_c;

  // two restoring divide steps by W' in joules
  always_comb begin
    rem_d = rem_q;
    acc_d = acc_q;
    for (int i = 0; i < 2; i++) begin
      rem_d = {rem_d[REM_W-2:0], acc_d[DIV_W-1]};
      acc_d = {acc_d[DIV_W-2:0], 1'b0};
      if (rem_d >= REM_W'(cfg_i.reserve_capacity)) begin
        rem_d    = rem_d - REM_W'(cfg_i.reserve_capacity);
        acc_d[0] = 1'b1;
      end
    end
  end

  // new balance: drain or recovery, cap at W', saturate to 32 bits
  assign wq_wide  = $signed(WIDE_W'(wq));
  assign bal_wide = WIDE_W'(bal_q);
  always_comb begin
    if (drain_q) begin
      wide = bal_wide - $signed(WIDE_W'(prod_a_q) << FRACTION_BITS);
    end else if (mag_neg_q) begin
      wide = bal_wide - $signed(WIDE_W'(acc_q));
    end else begin
      wide = bal_wide + $signed(WIDE_W'(acc_q));
    end
    if (wide > wq_wide) wide = wq_wide;
    priority if (wide > WIDE_BAL_MAX) bal_d = WIDE_BAL_MAX[BAL_W-1:0];
    else if (wide < WIDE_BAL_MIN)     bal_d = WIDE_BAL_MIN[BAL_W-1:0];
    else                              bal_d = wide[BAL_W-1:0];
  end

  // statistics on the committed balance
  assign twice_c = bal_c <<< 1;
  assign quad_c  = bal_c <<< 2;
  always_comb begin
    seen_d   = 1'b1;
    lowest_d = lowest_q;
    armed_d  = armed_q;
    count_d  = count_q;
    if (!seen_q) begin
      lowest_d = bal_q;
      armed_d  = quad_c >= wq3_c;
    end else begin
      if (bal_q < lowest_q) lowest_d = bal_q;
      if (armed_q && (twice_c < wq_c)) begin
        if (!(&count_q)) count_d = count_q + COUNT_BITS'(1);
        armed_d = 1'b0;
      end else if (!armed_q && (quad_c > wq3_c)) begin
        armed_d = 1'b1;
      end
    end
  end
  assign count_ext = CNT_EXT_W'(count_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_start_q <= start_ride_i;
      item_time_q  <= time_offset_i;
      item_power_q <= power_watts_i;
    end
    if (cmd_i.check) begin
      dt_q    <= dt_full[DT_W-1:0];
      drain_q <= drain_now;
      pdiff_q <= drain_now ? (item_power_q - cfg_i.critical_power)
                           : (cfg_i.critical_power - item_power_q);
    end
    if (cmd_i.mul1) begin
      prod_a_q  <= PROD_A_W'(pdiff_q * dt_q);
      mag_neg_q <= diff_c[CMP_W-1];
      mag_q     <= diff_c[CMP_W-1] ? MAG_W'(-diff_c) : MAG_W'(diff_c);
    end
    if (cmd_i.mul_lo) begin
      acc_q <= DIV_W'(prod_a_q * mag_q[MAG_LO_W-1:0]);
      rem_q <= '0;
    end
    if (cmd_i.mul_hi) begin
      acc_q <= acc_q + (DIV_W'(prod_a_q * mag_q[MAG_W-1:MAG_LO_W]) << MAG_LO_W);
    end
    if (cmd_i.div_step) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
    if (commit) begin
      out_time_q  <= item_time_q;
      out_bal_q   <= bal_q;
      out_power_q <= item_power_q;
      out_total_q <= count_ext[TOTAL_W-1:0];
      out_low_q   <= lowest_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_time_q <= '0;
      prior_seen_q <= 1'b0;
      bal_q        <= RESET_BAL;
      lowest_q     <= '0;
      seen_q       <= 1'b0;
      armed_q      <= 1'b0;
      count_q      <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.check) begin
        prior_time_q <= item_time_q;
        prior_seen_q <= 1'b1;
        if (item_start_q) begin
          bal_q    <= full_sat;
          lowest_q <= '0;
          seen_q   <= 1'b0;
          armed_q  <= 1'b0;
          count_q  <= '0;
        end
      end
      if (cmd_i.mul_lo) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step && !status_o.div_done) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.bal) bal_q <= bal_d;
      if (commit) begin
        lowest_q <= lowest_d;
        seen_q   <= seen_d;
        armed_q  <= armed_d;
        count_q  <= count_d;
      end
      // drop the beat once taken, load a new one when the sample commits
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sample_time_o       = out_time_q;
  assign balance_q8_o        = out_bal_q;
  assign sample_power_o      = out_power_q;
  assign match_total_o       = out_total_q;
  assign lowest_balance_q8_o = out_low_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bal |=> (CMP_W'(bal_q) <= wq_c))
    else $error("balance above full reserve after update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed sample not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.check |=> (count_q >= $past(count_q)))
    else $error("match count fell without a restart");

endmodule

`default_nettype wire

// ===== tb/tb_w_prime_balance_tracker.sv =====
// Self-checking bench for the W' balance tracker: directed rows, then random rides
// under several register settings. Needs wpbt_pkg and w_prime_balance_tracker.
module tb_w_prime_balance_tracker;
  import wpbt_pkg::*;

  localparam int     FRAC        = 8;
  localparam longint Q_ONE       = longint'(1) << FRAC;
  localparam int     SETTLE      = 48;
  localparam int     HOLD_CYCLES = 300;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_SAMPLE} check_e;
  typedef enum logic {ROW_POINT, ROW_SETUP} row_kind_e;

  typedef struct packed {
    logic signed [TIME_W-1:0] stamp;
    logic signed [BAL_W-1:0]  bal;
    logic [POWER_W-1:0]       watts;
    logic [TOTAL_W-1:0]       total;
    logic signed [BAL_W-1:0]  lowest;
  } sample_t;

  typedef struct {
    row_kind_e                kind;
    check_e                   chk;
    logic                     start;
    logic signed [TIME_W-1:0] stamp;
    logic [POWER_W-1:0]       watts;
    int                       cp;
    int                       wr;
    int                       lim;
    sample_t                  lit;
  } plan_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      start_ride_i;
  logic signed [TIME_W-1:0]  time_offset_i;
  logic [POWER_W-1:0]        power_watts_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [TIME_W-1:0]  sample_time_o;
  logic signed [BAL_W-1:0]   balance_q8_o;
  logic [POWER_W-1:0]        sample_power_o;
  logic [TOTAL_W-1:0]        match_total_o;
  logic signed [BAL_W-1:0]   lowest_balance_q8_o;

  w_prime_balance_tracker dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .start_ride_i        (start_ride_i),
    .time_offset_i       (time_offset_i),
    .power_watts_i       (power_watts_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .sample_time_o       (sample_time_o),
    .balance_q8_o        (balance_q8_o),
    .sample_power_o      (sample_power_o),
    .match_total_o       (match_total_o),
    .lowest_balance_q8_o (lowest_balance_q8_o)
  );

  // tracker state as the bench sees it
  logic [CP_W-1:0]          cp_reg;
  logic [RC_W-1:0]          wr_reg;
  logic [LIMIT_W-1:0]       gap_limit;
  logic signed [TIME_W-1:0] prev_stamp;
  bit                       prev_valid;
  logic signed [BAL_W-1:0]  wbal;
  logic signed [BAL_W-1:0]  wlow;
  bit                       any_sample;
  bit                       armed;
  logic [TOTAL_W-1:0]       hits;

  sample_t   pending_samples[$];
  plan_row_t plan[$];
  int        mismatches;
  int        ride_clock;
  bit        hold_req;
  bit        calm;
  bit        surge;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #(30_000_000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [BAL_W-1:0] sat32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'sd2147483648)) return 32'sh8000_0000;
    return v[BAL_W-1:0];
  endfunction

  function automatic longint reserve_q8();
    return longint'(wr_reg) << FRAC;
  endfunction

  // Advance the balance for one accepted point; return 1 when a sample comes out.
  function automatic bit advance_balance(input bit restart,
                                         input logic signed [TIME_W-1:0] stamp,
                                         input logic [POWER_W-1:0] watts,
                                         output sample_t s);
    longint t, last, gap, wq, b;
    longint unsigned mag, q;
    bit had_prev;
    s = '0;
    t = longint'(stamp);
    last = longint'(prev_stamp);
    had_prev = prev_valid;
    prev_stamp = stamp;
    prev_valid = 1'b1;
    if (restart) begin
      wbal = sat32(reserve_q8());
      wlow = '0;
      any_sample = 1'b0;
      armed = 1'b0;
      hits = '0;
      return 1'b0;
    end
    if (cp_reg == 0 || wr_reg == 0) return 1'b0;
    if (!had_prev || t < 0 || last < 0) return 1'b0;
    gap = t - last;
    if (gap <= 0 || gap > longint'(gap_limit)) return 1'b0;
    wq = reserve_q8();
    b = longint'(wbal);
    if (watts > cp_reg) begin
      b -= (longint'(watts) - longint'(cp_reg)) * gap * Q_ONE;
    end else begin
      // recovery also pulls down a balance left above a lowered reserve
      mag = (wq >= b) ? longint'(wq - b) : longint'(b - wq);
      q = ((longint'(cp_reg) - longint'(watts)) * mag * gap) / longint'(wr_reg);
      if (wq >= b) b += longint'(q);
      else b -= longint'(q);
    end
    if (b > wq) b = wq;
    wbal = sat32(b);
    b = longint'(wbal);
    if (!any_sample) begin
      any_sample = 1'b1;
      wlow = wbal;
      armed = (4 * b >= 3 * wq);
    end else begin
      if (wbal < wlow) wlow = wbal;
      if (armed && 2 * b < wq) begin
        if (hits != '1) hits++;
        armed = 1'b0;
      end else if (!armed && 4 * b > 3 * wq) begin
        armed = 1'b1;
      end
    end
    s.stamp = stamp;
    s.bal = wbal;
    s.watts = watts;
    s.total = hits;
    s.lowest = wlow;
    return 1'b1;
  endfunction

  function automatic sample_t make_sample(input int t, input int b, input int p,
                                          input int n, input int low);
    sample_t s;
    s.stamp = TIME_W'(t);
    s.bal = b;
    s.watts = POWER_W'(p);
    s.total = TOTAL_W'(n);
    s.lowest = low;
    return s;
  endfunction

  function automatic void add_point(input check_e chk, input bit start, input int stamp,
                                    input int watts, input sample_t lit);
    plan_row_t r;
    r.kind = ROW_POINT;
    r.chk = chk;
    r.start = start;
    r.stamp = TIME_W'(stamp);
    r.watts = POWER_W'(watts);
    r.cp = 0;
    r.wr = 0;
    r.lim = 0;
    r.lit = lit;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_setup(input int cp, input int wr, input int lim);
    plan_row_t r;
    r.kind = ROW_SETUP;
    r.chk = CHK_NONE;
    r.start = 1'b0;
    r.stamp = '0;
    r.watts = '0;
    r.cp = cp;
    r.wr = wr;
    r.lim = lim;
    r.lit = '0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [POWER_W-1:0] pick_watts();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return POWER_W'($urandom_range(0, 4095));
    if (surge ? r < 85 : r < 20) begin
      if (cp_reg == '1) return '1;
      return POWER_W'($urandom_range(int'(cp_reg) + 1, 4095));
    end
    return POWER_W'($urandom_range(0, int'(cp_reg)));
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 100)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_sample();
    sample_t want;
    if (pending_samples.size() == 0) begin
      flag_mismatch("sample with none pending", 32'(sample_time_o), '0);
      return;
    end
    want = pending_samples.pop_front();
    if (sample_time_o !== want.stamp)
      flag_mismatch("sample_time", 32'(sample_time_o), 32'(want.stamp));
    if (balance_q8_o !== want.bal) flag_mismatch("balance_q8", balance_q8_o, want.bal);
    if (sample_power_o !== want.watts)
      flag_mismatch("sample_power", 32'(sample_power_o), 32'(want.watts));
    if (match_total_o !== want.total)
      flag_mismatch("match_total", 32'(match_total_o), 32'(want.total));
    if (lowest_balance_q8_o !== want.lowest)
      flag_mismatch("lowest_balance_q8", lowest_balance_q8_o, want.lowest);
  endtask

  // Outputs only move at rising edges, so the beat taken at the next edge is stable here.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) check_sample();
  end

  initial begin : receiver
    int n;
    bit holding;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      repeat (1 + pick_idle()) @(posedge clk_i);
      holding = hold_req;
      n = holding ? HOLD_CYCLES : pick_idle();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
        if (holding) hold_req = 1'b0;
      end
    end
  end

  task automatic send_point(input bit restart, input logic signed [TIME_W-1:0] stamp,
                            input logic [POWER_W-1:0] watts, output bit fired,
                            output sample_t s);
    int gap;
    gap = hold_req ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_ride_i <= restart;
    time_offset_i <= stamp;
    power_watts_i <= watts;
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    @(posedge clk_i);
    fired = advance_balance(restart, stamp, watts, s);
  endtask

  // Drain the block, give a no-sample point time to finish, then write all registers.
  task automatic configure(input int cp, input int wr, input int lim);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_CRITICAL_POWER;
    cfg_data_i <= CFG_DATA_W'(cp);
    @(posedge clk_i);
    cfg_index_i <= CFG_RESERVE_CAPACITY;
    cfg_data_i <= CFG_DATA_W'(wr);
    @(posedge clk_i);
    cfg_index_i <= CFG_STOP_GAP_LIMIT;
    cfg_data_i <= CFG_DATA_W'(lim);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cp_reg = CP_W'(cp);
    wr_reg = RC_W'(wr);
    gap_limit = LIMIT_W'(lim);
  endtask

  // Mostly rides with valid gaps and random effort; some restarts, broken gaps and noise.
  task automatic ride_phase(input int items);
    int k, r, step, span;
    bit restart, fired;
    logic signed [TIME_W-1:0] stamp;
    logic [POWER_W-1:0] watts;
    sample_t s;
    for (k = 0; k < items; k++) begin
      restart = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        restart = 1'b1;
        if ($urandom_range(0, 4) == 0) ride_clock = $urandom_range(8388000, 8388607);
        else ride_clock = $urandom_range(0, 1000);
      end else if (r < 8) begin
        restart = $urandom_range(0, 1);
        ride_clock = $urandom();
      end else begin
        r = $urandom_range(0, 99);
        span = (gap_limit < 40) ? int'(gap_limit) : 40;
        if (r < 5) step = 0;
        else if (r < 10) step = int'(gap_limit) + 1;
        else if (r < 15) step = int'(gap_limit);
        else step = $urandom_range(1, span);
        ride_clock += step;
      end
      if ($urandom_range(0, 9) == 0) surge = !surge;
      watts = pick_watts();
      // wrap like the 24-bit field does
      stamp = ride_clock[TIME_W-1:0];
      ride_clock = int'(stamp);
      send_point(restart, stamp, watts, fired, s);
      if (fired) pending_samples.insert(pending_samples.size(), s);
    end
  endtask

  initial begin : stimulus
    bit fired;
    sample_t s;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_CRITICAL_POWER;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    start_ride_i <= 1'b0;
    time_offset_i <= '0;
    power_watts_i <= '0;
    mismatches = 0;
    hold_req = 1'b0;
    calm = 1'b0;
    surge = 1'b0;
    ride_clock = 0;
    cp_reg = CP_RESET;
    wr_reg = RC_RESET;
    gap_limit = LIMIT_RESET;
    prev_stamp = '0;
    prev_valid = 1'b0;
    wbal = sat32(reserve_q8());
    wlow = '0;
    any_sample = 1'b0;
    armed = 1'b0;
    hits = '0;

    // no previous point, then restart and the first two samples
    add_point(CHK_NONE, 1'b0, 5, 100, '0);
    add_point(CHK_NONE, 1'b1, 0, 0, '0);
    add_point(CHK_SAMPLE, 1'b0, 1, 250, make_sample(1, 5120000, 250, 0, 5120000));
    add_point(CHK_SAMPLE, 1'b0, 2, 4095, make_sample(2, 4135680, 4095, 0, 4135680));
    // zero gap, backward gap, gap one past the limit, gap at the limit
    add_point(CHK_NONE, 1'b0, 2, 300, '0);
    add_point(CHK_NONE, 1'b0, 1, 300, '0);
    add_point(CHK_NONE, 1'b0, 32, 0, '0);
    add_point(CHK_MODEL, 1'b0, 62, 0, '0);
    // unknown time now, then unknown previous time
    add_point(CHK_NONE, 1'b0, -1, 0, '0);
    add_point(CHK_NONE, 1'b0, 5, 0, '0);
    add_point(CHK_MODEL, 1'b0, 35, 4095, '0);
    add_point(CHK_MODEL, 1'b0, 36, 0, '0);
    add_point(CHK_NONE, 1'b1, 8388600, 4095, '0);
    add_point(CHK_MODEL, 1'b0, 8388607, 4095, '0);
    add_point(CHK_NONE, 1'b0, -8388608, 0, '0);
    // disabled by zero CP, then by zero reserve
    add_setup(0, 20000, 30);
    add_point(CHK_NONE, 1'b0, 20, 0, '0);
    add_point(CHK_NONE, 1'b0, 21, 500, '0);
    add_setup(250, 0, 30);
    add_point(CHK_NONE, 1'b0, 22, 500, '0);
    // widest gap fills to the cap, then a shrunk reserve pulls the balance down
    add_setup(4095, 65535, 65535);
    add_point(CHK_MODEL, 1'b0, 65557, 0, '0);
    add_setup(1, 1, 1);
    add_point(CHK_MODEL, 1'b0, 65558, 0, '0);
    add_point(CHK_NONE, 1'b0, 65560, 0, '0);
    // drain past the bottom of the range, then recover from there
    add_setup(1, 1, 65535);
    add_point(CHK_MODEL, 1'b0, 131095, 4095, '0);
    add_point(CHK_MODEL, 1'b0, 131096, 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETUP) begin
        configure(plan[i].cp, plan[i].wr, plan[i].lim);
      end else begin
        send_point(plan[i].start, plan[i].stamp, plan[i].watts, fired, s);
        case (plan[i].chk)
          CHK_MODEL: if (fired) pending_samples.insert(pending_samples.size(), s);
          CHK_SAMPLE: pending_samples.insert(pending_samples.size(), plan[i].lit);
          default: ;
        endcase
      end
    end

    configure(int'(CP_RESET), int'(RC_RESET), int'(LIMIT_RESET));
    ride_phase(250);
    // hold off until every sample is out
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_samples.size() != 0);
    ride_phase(250);
    configure(4095, 65535, 65535);
    ride_phase(100);
    configure(1, 1, 1);
    ride_phase(100);
    configure(0, 20000, 30);
    ride_phase(40);
    configure(250, 0, 30);
    ride_phase(30);
    configure($urandom_range(100, 500), $urandom_range(2000, 40000), $urandom_range(5, 60));
    ride_phase(150);
    configure($urandom_range(1, 4095), $urandom_range(1, 65535), $urandom_range(1, 65535));
    ride_phase(150);
    configure($urandom_range(100, 400), $urandom_range(500, 3000), $urandom_range(1, 20));
    ride_phase(150);
    configure(150, 5000, 10);
    calm = 1'b1;
    ride_phase(150);
    calm = 1'b0;
    // long receiver hold while points keep coming, so the input backs up
    configure(int'(CP_RESET), int'(RC_RESET), int'(LIMIT_RESET));
    hold_req = 1'b1;
    ride_phase(150);

    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
